// ===== hdl/icfalu_pkg.sv =====
// Shared types and constants for the 64-bit constant fold ALU.
`default_nettype none
package icfalu_pkg;

    localparam int unsigned DEFAULT_DATA_WIDTH = 64;
    localparam int unsigned VALUE_WIDTH = 64;
    localparam int unsigned MODE_WIDTH = 5;
    localparam int unsigned STATUS_WIDTH = 2;

    typedef enum logic [MODE_WIDTH-1:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_MUL    = 5'd2,
        OP_DIV    = 5'd3,
        OP_MOD    = 5'd4,
        OP_BITNOT = 5'd5,
        OP_AND    = 5'd6,
        OP_OR     = 5'd7,
        OP_XOR    = 5'd8,
        OP_SHL    = 5'd9,
        OP_SAR    = 5'd10,
        OP_LNOT   = 5'd11,
        OP_LAND   = 5'd12,
        OP_LOR    = 5'd13,
        OP_EQ     = 5'd14,
        OP_NE     = 5'd15,
        OP_LT     = 5'd16,
        OP_GT     = 5'd17,
        OP_LE     = 5'd18,
        OP_GE     = 5'd19,
        OP_NEG    = 5'd20,
        OP_POS    = 5'd21,
        OP_NOFOLD = 5'd22
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_SHIFT  = 2'd2,
        ST_DIVOVF = 2'd3
    } status_t;

    typedef struct packed {
        logic                   is_div;
        logic                   is_mod;
        logic                   neg_q;
        logic                   neg_r;
        logic                   fold;
        status_t                status;
        logic [VALUE_WIDTH-1:0] value;
    } side_t;

endpackage
`default_nettype wire

// ===== hdl/int64_constant_fold_alu.sv =====
// Top level of the pipelined 64-bit constant fold ALU.
// Every operator goes through the same pipeline: stage 1, stage 2, the divider
// stages, which resolve one quotient bit per stage, and the output stage.
// Throughput: one transfer per cycle unless m_axis_tready stalls the output.
// Reset: aresetn clears all stage valid bits; data registers are not reset.
`default_nettype none
module int64_constant_fold_alu #(
    parameter int unsigned DATA_WIDTH = icfalu_pkg::DEFAULT_DATA_WIDTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,   // left_value[63:0], right_value[127:64]
    input  wire logic [4:0]    s_axis_tuser,   // mode[4:0]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [63:0]        m_axis_tdata,   // value[63:0]
    output logic [7:0]         m_axis_tuser    // foldable[0], status[2:1], zero[7:3]
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned L  = W / 2;
    localparam int unsigned H  = W - L;
    localparam int unsigned SW = $clog2(W);

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: capture operands, form partial products
    logic              v1_reg;
    icfalu_pkg::op_t   mode1_reg;
    logic [W-1:0]      a1_reg;
    logic [W-1:0]      b1_reg;
    logic [2*L-1:0]    p0_reg;
    logic [W-1:0]      p1_reg;
    logic [W-1:0]      p2_reg;

    logic [W-1:0]   a_in;
    logic [W-1:0]   b_in;
    logic [2*L-1:0] p0_next;
    logic [L+H-1:0] p1_next;
    logic [L+H-1:0] p2_next;

    always_comb begin
        a_in    = s_axis_tdata[W-1:0];
        b_in    = s_axis_tdata[64 +: W];
        p0_next = a_in[L-1:0] * b_in[L-1:0];
        p1_next = a_in[L-1:0] * b_in[W-1:L];
        p2_next = a_in[W-1:L] * b_in[L-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= icfalu_pkg::op_t'(s_axis_tuser);
            a1_reg    <= a_in;
            b1_reg    <= b_in;
            p0_reg    <= p0_next;
            p1_reg    <= W'(p1_next);
            p2_reg    <= W'(p2_next);
        end
    end

    // stage 2: evaluate simple operators, finish product, set up division
    logic              v2_reg;
    icfalu_pkg::side_t side2_reg;
    logic [W-1:0]      dvd2_reg;
    logic [W-1:0]      dvs2_reg;

    icfalu_pkg::side_t side_next;
    logic [W-1:0]      dvd_next;
    logic [W-1:0]      dvs_next;
    logic [W-1:0]      r;
    logic [W-1:0]      prod;
    logic              a_neg;
    logic              b_neg;
    logic              lt_ab;
    logic              lt_ba;
    logic              shift_bad;
    logic [SW-1:0]     sh;
    logic [W-1:0]      min_val;

    always_comb begin
        a_neg     = a1_reg[W-1];
        b_neg     = b1_reg[W-1];
        lt_ab     = $signed(a1_reg) < $signed(b1_reg);
        lt_ba     = $signed(b1_reg) < $signed(a1_reg);
        shift_bad = b_neg || (b1_reg >= W'(W));
        sh        = b1_reg[SW-1:0];
        min_val   = {1'b1, {(W-1){1'b0}}};
        prod      = W'(p0_reg) + ((p1_reg + p2_reg) << L);
        dvd_next  = a_neg ? W'(-a1_reg) : a1_reg;
        dvs_next  = b_neg ? W'(-b1_reg) : b1_reg;
        r         = '0;
        side_next        = '0;
        side_next.fold   = 1'b1;
        side_next.status = icfalu_pkg::ST_OK;
        side_next.neg_q  = a_neg ^ b_neg;
        side_next.neg_r  = a_neg;
        unique case (mode1_reg)
            icfalu_pkg::OP_ADD:    r = a1_reg + b1_reg;
            icfalu_pkg::OP_SUB:    r = a1_reg - b1_reg;
            icfalu_pkg::OP_MUL:    r = prod;
            icfalu_pkg::OP_DIV, icfalu_pkg::OP_MOD: begin
                if (b1_reg == '0) begin
                    side_next.status = icfalu_pkg::ST_DIV0;
                end else if (a1_reg == min_val && b1_reg == '1) begin
                    side_next.status = icfalu_pkg::ST_DIVOVF;
                end else begin
                    side_next.is_div = (mode1_reg == icfalu_pkg::OP_DIV);
                    side_next.is_mod = (mode1_reg == icfalu_pkg::OP_MOD);
                end
            end
            icfalu_pkg::OP_BITNOT: r = ~b1_reg;
            icfalu_pkg::OP_AND:    r = a1_reg & b1_reg;
            icfalu_pkg::OP_OR:     r = a1_reg | b1_reg;
            icfalu_pkg::OP_XOR:    r = a1_reg ^ b1_reg;
            icfalu_pkg::OP_SHL: begin
                if (shift_bad) begin
                    side_next.status = icfalu_pkg::ST_SHIFT;
                end else begin
                    r = a1_reg << sh;
                end
            end
            icfalu_pkg::OP_SAR: begin
                if (shift_bad) begin
                    side_next.status = icfalu_pkg::ST_SHIFT;
                end else begin
                    r = W'($signed(a1_reg) >>> sh);
                end
            end
            icfalu_pkg::OP_LNOT:   r = W'(b1_reg == '0);
            icfalu_pkg::OP_LAND:   r = W'((a1_reg != '0) && (b1_reg != '0));
            icfalu_pkg::OP_LOR:    r = W'((a1_reg != '0) || (b1_reg != '0));
            icfalu_pkg::OP_EQ:     r = W'(a1_reg == b1_reg);
            icfalu_pkg::OP_NE:     r = W'(a1_reg != b1_reg);
            icfalu_pkg::OP_LT:     r = W'(lt_ab);
            icfalu_pkg::OP_GT:     r = W'(lt_ba);
            icfalu_pkg::OP_LE:     r = W'(!lt_ba);
            icfalu_pkg::OP_GE:     r = W'(!lt_ab);
            icfalu_pkg::OP_NEG:    r = -b1_reg;
            icfalu_pkg::OP_POS:    r = b1_reg;
            default:               side_next.fold = 1'b0;
        endcase
        side_next.value = icfalu_pkg::VALUE_WIDTH'($signed(r));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side_next;
            dvd2_reg  <= dvd_next;
            dvs2_reg  <= dvs_next;
        end
    end

    // divider stages
    logic              vd;
    icfalu_pkg::side_t sided;
    logic [W-1:0]      quo;
    logic [W-1:0]      rem;

    icfalu_divpipe #(
        .W (W)
    ) u_divpipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_side   (side2_reg),
        .in_dvd    (dvd2_reg),
        .in_dvs    (dvs2_reg),
        .out_valid (vd),
        .out_side  (sided),
        .out_quo   (quo),
        .out_rem   (rem)
    );

    // output stage: fix quotient and remainder signs, hold until transfer
    logic              vo_reg;
    logic [63:0]       value_reg;
    logic              fold_reg;
    icfalu_pkg::status_t status_reg;
    logic [W-1:0]      dres;
    logic [63:0]       value_next;

    always_comb begin
        dres = '0;
        if (sided.is_div) begin
            dres = sided.neg_q ? W'(-quo) : quo;
        end else if (sided.is_mod) begin
            dres = sided.neg_r ? W'(-rem) : rem;
        end
        if (sided.is_div || sided.is_mod) begin
            value_next = 64'($signed(dres));
        end else begin
            value_next = sided.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg  <= value_next;
            fold_reg   <= sided.fold;
            status_reg <= sided.status;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = {5'b0, status_reg, fold_reg};

endmodule
`default_nettype wire

// ===== hdl/icfalu_divpipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module icfalu_divpipe #(
    parameter int unsigned W = icfalu_pkg::DEFAULT_DATA_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  icfalu_pkg::side_t     in_side,
    input  wire logic [W-1:0]     in_dvd,
    input  wire logic [W-1:0]     in_dvs,
    output logic                  out_valid,
    output icfalu_pkg::side_t     out_side,
    output logic [W-1:0]          out_quo,
    output logic [W-1:0]          out_rem
);

    logic              valid_reg [W];
    icfalu_pkg::side_t side_reg  [W];
    logic [W-1:0]      rem_reg   [W];
    logic [W-1:0]      dvd_reg   [W];
    logic [W-1:0]      dvs_reg   [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic              v_src;
        icfalu_pkg::side_t side_src;
        logic [W-1:0]      rem_src;
        logic [W-1:0]      dvd_src;
        logic [W-1:0]      dvs_src;
        logic [W:0]        shifted;
        logic [W:0]        trial;
        logic [W-1:0]      rem_next;
        logic [W-1:0]      dvd_next;

        if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign side_src = in_side;
            assign rem_src  = '0;
            assign dvd_src  = in_dvd;
            assign dvs_src  = in_dvs;
        end else begin : g_rest
            assign v_src    = valid_reg[k-1];
            assign side_src = side_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign dvd_src  = dvd_reg[k-1];
            assign dvs_src  = dvs_reg[k-1];
        end

        always_comb begin
            shifted  = {rem_src, dvd_src[W-1]};
            trial    = shifted - {1'b0, dvs_src};
            rem_next = trial[W] ? shifted[W-1:0] : trial[W-1:0];
            dvd_next = {dvd_src[W-2:0], ~trial[W]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_src;
                rem_reg[k]  <= rem_next;
                dvd_reg[k]  <= dvd_next;
                dvs_reg[k]  <= dvs_src;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign out_side  = side_reg[W-1];
    assign out_quo   = dvd_reg[W-1];
    assign out_rem   = rem_reg[W-1];

endmodule
`default_nettype wire
